// ===== rtl/mbeq_pkg.sv =====
// Shared types and constants for the multiband biquad cascade equalizer.
package mbeq_pkg;

  localparam int unsigned MaxBands    = 16;
  localparam int unsigned MaxSections = 4;
  localparam int unsigned SampleBits  = 24;
  localparam int unsigned CoefBits    = 32;
  localparam int unsigned NCoef       = 5;
  localparam int unsigned SigBits     = 32;
  localparam int unsigned StateBits   = 40;
  localparam int unsigned AccBits     = 48;
  localparam int unsigned ProdShift   = 19;
  localparam int unsigned GainFrac    = 13;
  localparam int unsigned GainMax     = 32768;
  localparam int unsigned CDepth      = MaxBands * MaxSections;
  localparam int unsigned SecAddrBits = $clog2(CDepth);
  localparam int unsigned ZDepth      = 2 * CDepth;
  localparam int unsigned ZAddrBits   = SecAddrBits + 1;

  typedef enum logic [1:0] {
    ACT_FRAME = 2'd0,
    ACT_COEF  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    REG_EN     = 3'd0,
    REG_STEREO = 3'd1,
    REG_BANDS  = 3'd2,
    REG_MASK   = 3'd3,
    REG_COUNTS = 3'd4,
    REG_GAIN   = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    MUL_B0   = 3'd0,
    MUL_B1   = 3'd1,
    MUL_B2   = 3'd2,
    MUL_A1   = 3'd3,
    MUL_A2   = 3'd4,
    MUL_GAIN = 3'd5
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD = 3'd0,
    ACC_P_Z1 = 3'd1,
    ACC_P_Z2 = 3'd2,
    ACC_SAT  = 3'd3,
    ACC_SUB  = 3'd4
  } acc_op_t;

  typedef enum logic [1:0] {
    ACC2_HOLD = 2'd0,
    ACC2_LOAD = 2'd1,
    ACC2_SUB  = 2'd2
  } acc2_op_t;

  typedef enum logic [1:0] {
    X_HOLD  = 2'd0,
    X_LEFT  = 2'd1,
    X_RIGHT = 2'd2,
    X_Y     = 2'd3
  } x_op_t;

  typedef struct packed {
    logic        en;
    logic        stereo;
    logic [4:0]  nb;
    logic [15:0] mask;
    logic [31:0] counts;
    logic [15:0] gain;
  } cfg_t;

  typedef struct packed {
    logic                   in_load;
    logic                   res_init;
    logic                   cw_en;
    logic                   mem_rd;
    logic [SecAddrBits-1:0] sec_addr;
    logic                   ch;
    logic                   clr_z;
    logic                   clr_c;
    logic [ZAddrBits-1:0]   clr_addr;
    logic                   mul_en;
    mul_sel_t               mul_sel;
    logic                   rnd_en;
    acc_op_t                acc_op;
    acc2_op_t               acc2_op;
    logic                   y_en;
    logic                   zw_en;
    x_op_t                  x_op;
    logic                   gain_en;
    logic                   out_load;
  } cmd_t;

endpackage

// ===== rtl/mbeq_cfg.sv =====
// Configuration register file with clamping of band count and gain.
module mbeq_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata,
  output mbeq_pkg::cfg_t      cfg
);

  mbeq_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.en     <= 1'b0;
      cfg_r.stereo <= 1'b1;
      cfg_r.nb     <= '0;
      cfg_r.mask   <= '0;
      cfg_r.counts <= '0;
      cfg_r.gain   <= 16'd8192;
    end else if (cfg_we) begin
      case (cfg_index)
        mbeq_pkg::REG_EN:     cfg_r.en <= cfg_wdata[0];
        mbeq_pkg::REG_STEREO: cfg_r.stereo <= cfg_wdata[0];
        mbeq_pkg::REG_BANDS:
          cfg_r.nb <= (cfg_wdata[4:0] > 5'(mbeq_pkg::MaxBands)) ?
                      5'(mbeq_pkg::MaxBands) : cfg_wdata[4:0];
        mbeq_pkg::REG_MASK:   cfg_r.mask <= cfg_wdata[15:0];
        mbeq_pkg::REG_COUNTS: cfg_r.counts <= cfg_wdata;
        mbeq_pkg::REG_GAIN:
          cfg_r.gain <= (cfg_wdata[15:0] > 16'(mbeq_pkg::GainMax)) ?
                        16'(mbeq_pkg::GainMax) : cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/mbeq_datapath.sv =====
// Datapath: coefficient and history memories, shared multiplier, accumulators.
module mbeq_datapath (
  input  logic                                    clk,
  input  mbeq_pkg::cmd_t                          cmd,
  input  mbeq_pkg::cfg_t                          cfg,
  input  logic signed [mbeq_pkg::SampleBits-1:0]  in_left_in,
  input  logic signed [mbeq_pkg::SampleBits-1:0]  in_right_in,
  input  logic [3:0]                              in_coef_band,
  input  logic [1:0]                              in_coef_section,
  input  logic [2:0]                              in_coef_index,
  input  logic signed [mbeq_pkg::CoefBits-1:0]    in_coef_value,
  output logic signed [mbeq_pkg::SampleBits-1:0]  out_left_out,
  output logic signed [mbeq_pkg::SampleBits-1:0]  out_right_out
);

  localparam int unsigned CW   = mbeq_pkg::CoefBits;
  localparam int unsigned SW   = mbeq_pkg::SigBits;
  localparam int unsigned StW  = mbeq_pkg::StateBits;
  localparam int unsigned AccW = mbeq_pkg::AccBits;
  localparam int unsigned PW   = CW + SW;
  localparam int unsigned RW   = PW - mbeq_pkg::ProdShift;
  localparam int unsigned OW   = mbeq_pkg::SampleBits;

  function automatic logic signed [StW-1:0] sat_st(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = {{(AccW-StW+1){1'b0}}, {(StW-1){1'b1}}};
    lo = ~hi;
    if (v > hi) return hi[StW-1:0];
    if (v < lo) return lo[StW-1:0];
    return v[StW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] sat_sig(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = {{(AccW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    lo = ~hi;
    if (v > hi) return hi[SW-1:0];
    if (v < lo) return lo[SW-1:0];
    return v[SW-1:0];
  endfunction

  function automatic logic signed [OW-1:0] sat_out(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] lo;
    hi = {{(PW-OW+1){1'b0}}, {(OW-1){1'b1}}};
    lo = ~hi;
    if (v > hi) return hi[OW-1:0];
    if (v < lo) return lo[OW-1:0];
    return v[OW-1:0];
  endfunction

  logic signed [CW-1:0]   coef_q [mbeq_pkg::NCoef];
  logic signed [StW-1:0]  z1_q;
  logic signed [StW-1:0]  z2_q;
  logic [StW-1:0]         z1mem [mbeq_pkg::ZDepth];
  logic [StW-1:0]         z2mem [mbeq_pkg::ZDepth];
  logic [mbeq_pkg::ZAddrBits-1:0] z_addr;

  logic signed [OW-1:0]   right_r;
  logic signed [SW-1:0]   x_r;
  logic signed [SW-1:0]   y_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [RW-1:0]   prnd_r;
  logic signed [AccW-1:0] acc_r;
  logic signed [AccW-1:0] acc2_r;
  logic signed [OW-1:0]   res_l_r;
  logic signed [OW-1:0]   res_r_r;

  logic signed [CW-1:0]   op_a;
  logic signed [SW-1:0]   op_b;
  logic signed [PW-1:0]   rnd_sum;
  logic signed [PW-1:0]   gain_sum;
  logic signed [AccW-1:0] y_sum;
  logic signed [OW-1:0]   gain_res;

  genvar gk;
  generate
    for (gk = 0; gk < mbeq_pkg::NCoef; gk++) begin : g_cmem
      logic [CW-1:0] mem [mbeq_pkg::CDepth];
      always_ff @(posedge clk) begin
        if (cmd.clr_c) begin
          mem[cmd.clr_addr[mbeq_pkg::SecAddrBits-1:0]] <= '0;
        end else if (cmd.cw_en && (in_coef_index == 3'(gk))) begin
          mem[{in_coef_band, in_coef_section}] <= in_coef_value;
        end
        if (cmd.mem_rd) begin
          coef_q[gk] <= mem[cmd.sec_addr];
        end
      end
    end
  endgenerate

  assign z_addr = cmd.clr_z ? cmd.clr_addr : {cmd.sec_addr, cmd.ch};

  always_ff @(posedge clk) begin
    if (cmd.clr_z) begin
      z1mem[z_addr] <= '0;
      z2mem[z_addr] <= '0;
    end else if (cmd.zw_en) begin
      z1mem[z_addr] <= sat_st(acc_r);
      z2mem[z_addr] <= sat_st(acc2_r);
    end
    if (cmd.mem_rd) begin
      z1_q <= z1mem[z_addr];
      z2_q <= z2mem[z_addr];
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      mbeq_pkg::MUL_B0:   op_a = coef_q[0];
      mbeq_pkg::MUL_B1:   op_a = coef_q[1];
      mbeq_pkg::MUL_B2:   op_a = coef_q[2];
      mbeq_pkg::MUL_A1:   op_a = coef_q[3];
      mbeq_pkg::MUL_A2:   op_a = coef_q[4];
      mbeq_pkg::MUL_GAIN: op_a = CW'({1'b0, cfg.gain});
      default:            op_a = '0;
    endcase
    case (cmd.mul_sel)
      mbeq_pkg::MUL_A1, mbeq_pkg::MUL_A2: op_b = y_r;
      default:                            op_b = x_r;
    endcase
  end

  assign rnd_sum  = prod_r + PW'(64'sd1 <<< (mbeq_pkg::ProdShift - 1));
  assign gain_sum = prod_r + PW'(64'sd1 <<< (mbeq_pkg::GainFrac - 1));
  assign gain_res = sat_out(gain_sum >>> mbeq_pkg::GainFrac);
  assign y_sum    = acc_r + AccW'(128);

  always_ff @(posedge clk) begin
    if (cmd.in_load) right_r <= in_right_in;
    if (cmd.mul_en) prod_r <= PW'(op_a) * PW'(op_b);
    if (cmd.rnd_en) prnd_r <= rnd_sum[PW-1:mbeq_pkg::ProdShift];

    case (cmd.acc_op)
      mbeq_pkg::ACC_P_Z1: acc_r <= AccW'(prnd_r) + AccW'(z1_q);
      mbeq_pkg::ACC_P_Z2: acc_r <= AccW'(prnd_r) + AccW'(z2_q);
      mbeq_pkg::ACC_SAT:  acc_r <= AccW'(sat_st(acc_r));
      mbeq_pkg::ACC_SUB:  acc_r <= acc_r - AccW'(prnd_r);
      default: ;
    endcase

    case (cmd.acc2_op)
      mbeq_pkg::ACC2_LOAD: acc2_r <= AccW'(prnd_r);
      mbeq_pkg::ACC2_SUB:  acc2_r <= acc2_r - AccW'(prnd_r);
      default: ;
    endcase

    // y = sat32((acc + 2^7) >> 8)
    if (cmd.y_en) y_r <= sat_sig(y_sum >>> 8);

    case (cmd.x_op)
      mbeq_pkg::X_LEFT:  x_r <= SW'(in_left_in);
      mbeq_pkg::X_RIGHT: x_r <= SW'(right_r);
      mbeq_pkg::X_Y:     x_r <= y_r;
      default: ;
    endcase

    if (cmd.res_init) begin
      res_l_r <= in_left_in;
      res_r_r <= cfg.stereo ? in_right_in : '0;
    end else if (cmd.gain_en) begin
      if (cmd.ch) res_r_r <= gain_res;
      else        res_l_r <= gain_res;
    end

    if (cmd.out_load) begin
      out_left_out  <= res_l_r;
      out_right_out <= res_r_r;
    end
  end

endmodule

// ===== rtl/mbeq_ctrl.sv =====
// Controller: beat acceptance, band/section sequencing, clearing sweeps, output valid.
module mbeq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  mbeq_pkg::cfg_t cfg,
  input  logic           in_valid,
  input  logic [1:0]     in_action,
  input  logic [2:0]     in_coef_index,
  input  logic           out_stall,
  output logic           in_stall,
  output logic           out_valid,
  output mbeq_pkg::cmd_t cmd
);

  localparam int unsigned ZAW = mbeq_pkg::ZAddrBits;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLR, ST_SEL, ST_RD, ST_B0, ST_RND0, ST_B1, ST_SAT, ST_Y,
    ST_A1, ST_A2, ST_SUB1, ST_SUB2, ST_WB, ST_GMUL, ST_GRND, ST_DONE
  } state_t;

  state_t         state_r;
  logic [4:0]     band_r;
  logic [1:0]     sec_r;
  logic           ch_r;
  logic [ZAW-1:0] cnt_r;
  logic           clr_c_r;
  logic           out_valid_r;

  logic accept;
  logic bypass;
  logic last_sec;
  logic out_free;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign bypass   = !cfg.en || (cfg.nb == '0);
  assign last_sec = (sec_r == cfg.counts[{band_r[3:0], 1'b0} +: 2]);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.sec_addr = {band_r[3:0], sec_r};
    cmd.ch       = ch_r;
    cmd.clr_addr = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (mbeq_pkg::action_t'(in_action))
            mbeq_pkg::ACT_FRAME: begin
              cmd.in_load  = 1'b1;
              cmd.res_init = 1'b1;
              cmd.x_op     = mbeq_pkg::X_LEFT;
            end
            mbeq_pkg::ACT_COEF: cmd.cw_en = (in_coef_index < 3'(mbeq_pkg::NCoef));
            default: ;
          endcase
        end
      end
      ST_CLR: begin
        cmd.clr_z = 1'b1;
        cmd.clr_c = clr_c_r && (cnt_r < ZAW'(mbeq_pkg::CDepth));
      end
      ST_RD: cmd.mem_rd = 1'b1;
      ST_B0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mbeq_pkg::MUL_B0;
      end
      ST_RND0: cmd.rnd_en = 1'b1;
      ST_B1: begin
        cmd.acc_op  = mbeq_pkg::ACC_P_Z1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mbeq_pkg::MUL_B1;
      end
      ST_SAT: begin
        cmd.acc_op = mbeq_pkg::ACC_SAT;
        cmd.rnd_en = 1'b1;
      end
      ST_Y: begin
        cmd.y_en    = 1'b1;
        cmd.acc_op  = mbeq_pkg::ACC_P_Z2;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mbeq_pkg::MUL_B2;
      end
      ST_A1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mbeq_pkg::MUL_A1;
        cmd.rnd_en  = 1'b1;
      end
      ST_A2: begin
        cmd.acc2_op = mbeq_pkg::ACC2_LOAD;
        cmd.rnd_en  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mbeq_pkg::MUL_A2;
      end
      ST_SUB1: begin
        cmd.acc_op = mbeq_pkg::ACC_SUB;
        cmd.rnd_en = 1'b1;
      end
      ST_SUB2: cmd.acc2_op = mbeq_pkg::ACC2_SUB;
      ST_WB: begin
        cmd.zw_en = 1'b1;
        cmd.x_op  = mbeq_pkg::X_Y;
      end
      ST_GMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mbeq_pkg::MUL_GAIN;
      end
      ST_GRND: begin
        cmd.gain_en = 1'b1;
        if (!ch_r && cfg.stereo) cmd.x_op = mbeq_pkg::X_RIGHT;
      end
      ST_DONE: cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      cnt_r       <= '0;
      clr_c_r     <= 1'b1;
      band_r      <= '0;
      sec_r       <= '0;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (mbeq_pkg::action_t'(in_action))
              mbeq_pkg::ACT_FRAME: begin
                ch_r    <= 1'b0;
                band_r  <= '0;
                state_r <= bypass ? ST_DONE : ST_SEL;
              end
              mbeq_pkg::ACT_CLEAR: begin
                cnt_r   <= '0;
                clr_c_r <= 1'b0;
                state_r <= ST_CLR;
              end
              default: ;
            endcase
          end
        end
        ST_CLR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == ZAW'(mbeq_pkg::ZDepth - 1)) state_r <= ST_IDLE;
        end
        ST_SEL: begin
          if (band_r == cfg.nb) begin
            state_r <= ST_GMUL;
          end else if (!cfg.mask[band_r[3:0]]) begin
            band_r <= band_r + 1'b1;
          end else begin
            sec_r   <= '0;
            state_r <= ST_RD;
          end
        end
        ST_RD:   state_r <= ST_B0;
        ST_B0:   state_r <= ST_RND0;
        ST_RND0: state_r <= ST_B1;
        ST_B1:   state_r <= ST_SAT;
        ST_SAT:  state_r <= ST_Y;
        ST_Y:    state_r <= ST_A1;
        ST_A1:   state_r <= ST_A2;
        ST_A2:   state_r <= ST_SUB1;
        ST_SUB1: state_r <= ST_SUB2;
        ST_SUB2: state_r <= ST_WB;
        ST_WB: begin
          if (last_sec) begin
            band_r  <= band_r + 1'b1;
            state_r <= ST_SEL;
          end else begin
            sec_r   <= sec_r + 1'b1;
            state_r <= ST_RD;
          end
        end
        ST_GMUL: state_r <= ST_GRND;
        ST_GRND: begin
          if (!ch_r && cfg.stereo) begin
            ch_r    <= 1'b1;
            band_r  <= '0;
            state_r <= ST_SEL;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: if (out_free) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_band_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEL) |-> (band_r <= cfg.nb))
    else $error("band counter past active band count");

  a_out_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result load did not raise valid");

  a_clr_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR && cnt_r != ZAW'(mbeq_pkg::ZDepth - 1)) |=> (state_r == ST_CLR))
    else $error("clearing sweep left early");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");
`endif

endmodule

// ===== rtl/multiband_biquad_cascade_eq.sv =====
// Top level of the multiband biquad cascade equalizer.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------
//  input   | in_action, in_left_in .. in_coef_value  | in_valid / in_stall
//  result  | out_left_out, out_right_out             | out_valid / out_stall
//  config  | cfg_index, cfg_wdata                    | cfg_we, no wait
//
//  One beat at a time. A filtered frame visits each of the nb active bands
//  per channel and runs the 11-step section schedule on one shared 32x32
//  multiplier for every section of each enabled band, then applies the gain.
//  After reset a sweep clears coefficients and history (in_stall high).
//  A finished result waits in the output register while out_stall is high.
module multiband_biquad_cascade_eq (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [1:0]                              in_action,
  input  logic signed [mbeq_pkg::SampleBits-1:0]  in_left_in,
  input  logic signed [mbeq_pkg::SampleBits-1:0]  in_right_in,
  input  logic [3:0]                              in_coef_band,
  input  logic [1:0]                              in_coef_section,
  input  logic [2:0]                              in_coef_index,
  input  logic signed [mbeq_pkg::CoefBits-1:0]    in_coef_value,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [mbeq_pkg::SampleBits-1:0]  out_left_out,
  output logic signed [mbeq_pkg::SampleBits-1:0]  out_right_out,
  input  logic                                    cfg_we,
  input  logic [2:0]                              cfg_index,
  input  logic [31:0]                             cfg_wdata
);

  mbeq_pkg::cfg_t cfg;
  mbeq_pkg::cmd_t cmd;

  mbeq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mbeq_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_action     (in_action),
    .in_coef_index (in_coef_index),
    .out_stall     (out_stall),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .cmd           (cmd)
  );

  mbeq_datapath u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .cfg             (cfg),
    .in_left_in      (in_left_in),
    .in_right_in     (in_right_in),
    .in_coef_band    (in_coef_band),
    .in_coef_section (in_coef_section),
    .in_coef_index   (in_coef_index),
    .in_coef_value   (in_coef_value),
    .out_left_out    (out_left_out),
    .out_right_out   (out_right_out)
  );

endmodule
